/* sv/tick_to_millisecond_timer_top_defines.svh */
// Assertion macros shared by the millisecond timer RTL.
`ifndef TICK_TO_MILLISECOND_TIMER_TOP_DEFINES_SVH
`define TICK_TO_MILLISECOND_TIMER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define TTMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define TTMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ttms_pkg.sv */
// Shared constants and command codes of the tick to millisecond timer.
`default_nettype none

package ttms_pkg;

  localparam int unsigned TICK_FREQUENCY_DEF = 10000;
  localparam int unsigned COUNTER_BITS_DEF   = 32;

  localparam logic [63:0] U32_ALL_ONES = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MS_PER_S     = 64'd1000;

  // Reciprocal scaling shift used for the constant division by the tick rate.
  localparam int unsigned RECIP_SHIFT = 63;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_CLEAR   = 3'd1,
    CMD_SAVE    = 3'd2,
    CMD_RESTORE = 3'd3,
    CMD_SERVICE = 3'd4
  } cmd_e;

endpackage

`default_nettype wire

/* sv/tick_to_millisecond_timer_top.sv */
// Four stages: widen and fold (stage 0), two 32x32 partial products, a final
// sum and shift, and the output register. Throughput: one beat per cycle
// unless out_stall_i back-pressure or a restore hazard holds the input.
// A restore beat is held off while a save beat is still in the pipeline.
// Reset (asynchronous, active low) clears all timer state and empties the
// pipeline; the block accepts beats from the first cycle after reset.
`default_nettype none

`include "tick_to_millisecond_timer_top_defines.svh"

module tick_to_millisecond_timer_top #(
  parameter int unsigned TICK_FREQUENCY = ttms_pkg::TICK_FREQUENCY_DEF,
  parameter int unsigned COUNTER_BITS   = ttms_pkg::COUNTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  in_command_i,
  input  logic [31:0] in_counter_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_milliseconds_o
);

  // ceil(t * 1000 / F) = (t * K1 + K0) >> 63 with M = ceil(2^63 / F).
  localparam logic [127:0] FREQ_W   = 128'(TICK_FREQUENCY);
  localparam logic [127:0] RECIP_M  =
    ((128'd1 << ttms_pkg::RECIP_SHIFT) + FREQ_W - 128'd1) / FREQ_W;
  localparam logic [127:0] K1_FULL  = RECIP_M * 128'(ttms_pkg::MS_PER_S);
  localparam logic [127:0] K0_FULL  = RECIP_M * (FREQ_W - 128'd1);
  localparam logic [31:0]  K1_LO    = K1_FULL[31:0];
  localparam logic [31:0]  K1_HI    = K1_FULL[63:32];
  localparam logic [96:0]  K0       = K0_FULL[96:0];

  localparam logic [63:0]  FREQ_64    = 64'(TICK_FREQUENCY);
  localparam logic [31:0]  FOLD_TICKS =
    32'((ttms_pkg::U32_ALL_ONES / FREQ_64) * FREQ_64);
  localparam logic [31:0]  FOLD_MS    =
    32'((ttms_pkg::U32_ALL_ONES / FREQ_64) * ttms_pkg::MS_PER_S);
  localparam logic [31:0]  WRAP_STEP  = 32'(64'd1 << COUNTER_BITS);

  // Timer state.
  logic [COUNTER_BITS-1:0] prev_sample_q, prev_sample_d;
  logic [31:0]             wrap_ext_q, wrap_ext_d;
  logic [31:0]             epoch_ticks_q, epoch_ticks_d;
  logic [31:0]             prev_rel_q, prev_rel_d;
  logic [31:0]             epoch_ms_q, epoch_ms_d;
  logic [31:0]             stored_ms_q;

  // Pipeline registers.
  logic        v0_q, v1_q, v2_q, out_v_q;
  logic        read0_q, read1_q, read2_q;
  logic        save0_q, save1_q, save2_q;
  logic [31:0] ticks0_q;
  logic [31:0] ms0_q, ms1_q, ms2_q;
  logic [63:0] prod_lo_q, prod_hi_q;
  logic [31:0] quot_q;
  logic [31:0] out_ms_q;

  logic        rdy_out, rdy2, rdy1, rdy0;
  logic        save_busy, hazard, accept;
  logic        in_read, in_save;
  logic [COUNTER_BITS-1:0] sample_masked;
  logic [31:0] wide_ticks, rel_ticks;
  logic [96:0] scaled_sum;
  logic [31:0] result_ms;

  assign rdy_out = !out_v_q || !out_stall_i;
  assign rdy2    = !v2_q || rdy_out;
  assign rdy1    = !v1_q || rdy2;
  assign rdy0    = !v0_q || rdy1;

  assign save_busy  = (v0_q && save0_q) || (v1_q && save1_q) || (v2_q && save2_q);
  assign hazard     = (in_command_i == ttms_pkg::CMD_RESTORE) && save_busy;
  assign in_stall_o = !rdy0 || hazard;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_read = (in_command_i == ttms_pkg::CMD_READ) ||
                   (in_command_i == ttms_pkg::CMD_SAVE);
  assign in_save = (in_command_i == ttms_pkg::CMD_SAVE);

  // Counter widening, epoch handling and the backwards fold.
  always_comb begin
    prev_sample_d = prev_sample_q;
    wrap_ext_d    = wrap_ext_q;
    epoch_ticks_d = epoch_ticks_q;
    prev_rel_d    = prev_rel_q;
    epoch_ms_d    = epoch_ms_q;
    sample_masked = in_counter_sample_i[COUNTER_BITS-1:0];
    rel_ticks     = '0;

    if (COUNTER_BITS < 32) begin
      if (sample_masked < prev_sample_q) begin
        wrap_ext_d = wrap_ext_q + WRAP_STEP;
      end
      prev_sample_d = sample_masked;
      wide_ticks    = 32'(sample_masked) + wrap_ext_d;
    end else begin
      wide_ticks = in_counter_sample_i;
    end

    unique case (in_command_i) inside
      ttms_pkg::CMD_READ, ttms_pkg::CMD_SAVE: begin
        rel_ticks = wide_ticks - epoch_ticks_q;
        if (rel_ticks < prev_rel_q) begin
          rel_ticks     = rel_ticks - FOLD_TICKS;
          epoch_ticks_d = epoch_ticks_q + FOLD_TICKS;
          epoch_ms_d    = epoch_ms_q + FOLD_MS;
        end
        prev_rel_d = rel_ticks;
      end
      ttms_pkg::CMD_CLEAR: begin
        epoch_ticks_d = wide_ticks;
        prev_rel_d    = '0;
        epoch_ms_d    = '0;
      end
      ttms_pkg::CMD_RESTORE: begin
        epoch_ticks_d = wide_ticks;
        prev_rel_d    = '0;
        epoch_ms_d    = stored_ms_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sample_q <= '0;
      wrap_ext_q    <= '0;
      epoch_ticks_q <= '0;
      prev_rel_q    <= '0;
      epoch_ms_q    <= '0;
    end else if (accept) begin
      prev_sample_q <= prev_sample_d;
      wrap_ext_q    <= wrap_ext_d;
      epoch_ticks_q <= epoch_ticks_d;
      prev_rel_q    <= prev_rel_d;
      epoch_ms_q    <= epoch_ms_d;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q <= accept;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy_out) begin
        out_v_q <= v2_q;
      end
    end
  end

  assign scaled_sum = {1'b0, prod_hi_q, 32'd0} + 97'(prod_lo_q) + K0;
  assign result_ms  = read2_q ? (quot_q + ms2_q) : '0;

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (rdy0 && accept) begin
      ticks0_q <= rel_ticks;
      ms0_q    <= epoch_ms_d;
      read0_q  <= in_read;
      save0_q  <= in_save;
    end
    if (rdy1 && v0_q) begin
      prod_lo_q <= ticks0_q * K1_LO;
      prod_hi_q <= ticks0_q * K1_HI;
      ms1_q     <= ms0_q;
      read1_q   <= read0_q;
      save1_q   <= save0_q;
    end
    if (rdy2 && v1_q) begin
      quot_q  <= scaled_sum[ttms_pkg::RECIP_SHIFT +: 32];
      ms2_q   <= ms1_q;
      read2_q <= read1_q;
      save2_q <= save1_q;
    end
    if (rdy_out && v2_q) begin
      out_ms_q <= result_ms;
    end
  end

  // The saved value is written as its beat enters the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_ms_q <= '0;
    end else if (rdy_out && v2_q && save2_q) begin
      stored_ms_q <= result_ms;
    end
  end

  assign out_valid_o        = out_v_q;
  assign out_milliseconds_o = out_ms_q;

  `TTMS_ASSERT_IMP(a_restore_after_save,
    accept && (in_command_i == ttms_pkg::CMD_RESTORE), !save_busy,
    "restore accepted while a save beat is in flight")

  `TTMS_ASSERT_NXT(a_read_tracks_prev,
    accept && in_read, ticks0_q == prev_rel_q && ms0_q == epoch_ms_q,
    "stage 0 ticks disagree with the recorded relative ticks")

  `TTMS_ASSERT_NXT(a_clear_resets_offsets,
    accept && (in_command_i == ttms_pkg::CMD_CLEAR),
    epoch_ms_q == 32'd0 && prev_rel_q == 32'd0,
    "clear did not reset the millisecond offset")

  `TTMS_ASSERT_NXT(a_stored_only_on_save,
    !(rdy_out && v2_q && save2_q), $stable(stored_ms_q),
    "stored milliseconds changed without a save beat")

endmodule

`default_nettype wire

/* tb/sv/tick_to_millisecond_timer_top_tb.sv */
// Self-checking testbench for the tick to millisecond timer, with a scoreboard and random stalls.
`timescale 1ns / 1ps

module tick_to_millisecond_timer_top_tb;

  localparam int unsigned TICK_FREQ    = ttms_pkg::TICK_FREQUENCY_DEF;
  localparam int unsigned CNT_BITS     = ttms_pkg::COUNTER_BITS_DEF;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_BEATS = 600;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned IDLE_LIMIT   = 2000;

  localparam logic [63:0] TICK_DIV   = (TICK_FREQ == 0) ? 64'd1 : 64'(TICK_FREQ);
  localparam logic [31:0] FOLD_TICKS =
    32'((ttms_pkg::U32_ALL_ONES / TICK_DIV) * TICK_DIV);

  // Tracks the timer state and holds the milliseconds still to come out.
  class ms_scoreboard;
    logic [31:0] prev_raw;
    logic [31:0] wrap_ext;
    logic [31:0] epoch_ticks;
    logic [31:0] prev_rel_ticks;
    logic [31:0] epoch_ms;
    logic [31:0] stored_ms;
    logic [31:0] expected_ms_q[$];
    int unsigned errors;

    function new();
      prev_raw       = '0;
      wrap_ext       = '0;
      epoch_ticks    = '0;
      prev_rel_ticks = '0;
      epoch_ms       = '0;
      stored_ms      = '0;
      errors         = 0;
    endfunction

    // Rounds up, so a single tick already counts as one millisecond.
    function logic [31:0] ticks_to_ms(logic [31:0] ticks);
      logic [63:0] scaled;
      scaled = {32'd0, ticks} * ttms_pkg::MS_PER_S + TICK_DIV - 64'd1;
      return 32'(scaled / TICK_DIV);
    endfunction

    function logic [31:0] widen(logic [31:0] raw);
      logic [31:0] masked;
      if (CNT_BITS >= 32) return raw;
      masked = raw & 32'((64'd1 << CNT_BITS) - 64'd1);
      if (masked < prev_raw) wrap_ext += 32'(64'd1 << CNT_BITS);
      prev_raw = masked;
      return masked + wrap_ext;
    endfunction

    function logic [31:0] elapsed_ms(logic [31:0] raw);
      logic [31:0] ticks;
      ticks = widen(raw) - epoch_ticks;
      // Relative ticks going backwards means a wrap: fold back whole seconds.
      if (ticks < prev_rel_ticks) begin
        ticks       -= FOLD_TICKS;
        epoch_ticks += FOLD_TICKS;
        epoch_ms    += ticks_to_ms(FOLD_TICKS);
      end
      prev_rel_ticks = ticks;
      return ticks_to_ms(ticks) + epoch_ms;
    endfunction

    function void note_beat(logic [2:0] cmd, logic [31:0] raw);
      logic [31:0] ms;
      ms = '0;
      case (cmd)
        ttms_pkg::CMD_READ: begin
          ms = elapsed_ms(raw);
        end
        ttms_pkg::CMD_CLEAR: begin
          epoch_ticks    = widen(raw);
          prev_rel_ticks = '0;
          epoch_ms       = '0;
        end
        ttms_pkg::CMD_SAVE: begin
          ms        = elapsed_ms(raw);
          stored_ms = ms;
        end
        ttms_pkg::CMD_RESTORE: begin
          epoch_ticks    = widen(raw);
          prev_rel_ticks = '0;
          epoch_ms       = stored_ms;
        end
        default: begin
          void'(widen(raw));
        end
      endcase
      expected_ms_q.push_back(ms);
    endfunction

    function void check_beat(logic [31:0] ms);
      logic [31:0] want;
      if (expected_ms_q.size() == 0) begin
        $error("unexpected result beat: milliseconds %0d", ms);
        errors++;
        return;
      end
      want = expected_ms_q.pop_front();
      if (ms !== want) begin
        $error("milliseconds mismatch: expected %0d, actual %0d", want, ms);
        errors++;
      end
    endfunction

    function int pending();
      return expected_ms_q.size();
    endfunction
  endclass

  logic        clk_i               = 1'b0;
  logic        rst_ni              = 1'b0;
  logic        in_valid_i          = 1'b0;
  logic        in_stall_o;
  logic [2:0]  in_command_i        = ttms_pkg::CMD_READ;
  logic [31:0] in_counter_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i         = 1'b0;
  logic [31:0] out_milliseconds_o;

  ms_scoreboard sb;
  logic [31:0]  tick_now = '0;
  bit           calm     = 1'b0;
  bit           hold_req = 1'b0;
  int unsigned  idle_cycles = 0;

  tick_to_millisecond_timer_top #(
    .TICK_FREQUENCY(TICK_FREQ),
    .COUNTER_BITS  (CNT_BITS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_command_i       (in_command_i),
    .in_counter_sample_i(in_counter_sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_milliseconds_o (out_milliseconds_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Results are checked before the new input is noted, so a beat never meets itself.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_beat(out_milliseconds_o);
      if (in_valid_i && !in_stall_o) sb.note_beat(in_command_i, in_counter_sample_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm || hold_req) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver side: random stall stretches, plus one long hold-off on request.
  initial begin
    int unsigned len;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        len = pick_gap();
        if (len == 0) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(1, 8);
        end else begin
          out_stall_i <= 1'b1;
        end
        repeat (len) @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(input logic [2:0] cmd, input logic [31:0] raw);
    int unsigned gap;
    in_valid_i          <= 1'b1;
    in_command_i        <= cmd;
    in_counter_sample_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] next_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) tick_now += $urandom_range(0, 40);
    else if (r < 80) tick_now += $urandom_range(41, 200000);
    else if (r < 88) tick_now -= $urandom_range(1, 5000000);
    else if (r < 94) tick_now = 32'hFFFF_FFFF - $urandom_range(0, 300);
    else tick_now = $urandom();
    return tick_now;
  endfunction

  function automatic logic [2:0] next_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return ttms_pkg::CMD_READ;
    if (r < 62) return ttms_pkg::CMD_SAVE;
    if (r < 70) return ttms_pkg::CMD_RESTORE;
    if (r < 77) return ttms_pkg::CMD_CLEAR;
    if (r < 90) return ttms_pkg::CMD_SERVICE;
    return 3'(ttms_pkg::CMD_SERVICE) + 3'($urandom_range(1, 3));
  endfunction

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Rounding edges, the counter extremes, backward steps that force a fold and every command.
    send_beat(ttms_pkg::CMD_READ, 32'd0);
    send_beat(ttms_pkg::CMD_READ, 32'd1);
    send_beat(ttms_pkg::CMD_READ, 32'd10);
    send_beat(ttms_pkg::CMD_READ, 32'd11);
    send_beat(ttms_pkg::CMD_READ, 32'hFFFF_FFFF);
    send_beat(ttms_pkg::CMD_SAVE, 32'hFFFF_FFFF);
    send_beat(ttms_pkg::CMD_READ, 32'd5);
    send_beat(ttms_pkg::CMD_SERVICE, 32'hFFFF_FFFF);
    send_beat(3'(ttms_pkg::CMD_SERVICE) + 3'd1, 32'hAAAA_AAAA);
    send_beat(3'(ttms_pkg::CMD_SERVICE) + 3'd2, 32'h5555_5555);
    send_beat(3'(ttms_pkg::CMD_SERVICE) + 3'd3, 32'd0);
    send_beat(ttms_pkg::CMD_RESTORE, 32'd100);
    send_beat(ttms_pkg::CMD_READ, 32'd200);
    send_beat(ttms_pkg::CMD_CLEAR, 32'd1000);
    send_beat(ttms_pkg::CMD_READ, 32'd1000);
    send_beat(ttms_pkg::CMD_READ, 32'd500);
    // A restore straight behind a save has to see the freshly stored value.
    send_beat(ttms_pkg::CMD_SAVE, 32'd123456);
    send_beat(ttms_pkg::CMD_RESTORE, 32'd7);
    send_beat(ttms_pkg::CMD_READ, 32'd8);
    send_beat(ttms_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    send_beat(ttms_pkg::CMD_READ, 32'd3);
    send_beat(ttms_pkg::CMD_READ, 32'hFFFF_FFFF);

    for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
      calm = (i >= 200) && (i < 280);
      if (i == 400) hold_req = 1'b1;
      send_beat(next_command(), next_sample());
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/ttms_pkg.sv
sv/tick_to_millisecond_timer_top.sv
tb/sv/tick_to_millisecond_timer_top_tb.sv
